// ----- hdl/bounded_positional_list_macros.svh -----
// Assertion macros for the bounded positional list.
// Included by the modules that carry concurrent checks.
`ifndef BOUNDED_POSITIONAL_LIST_MACROS_SVH
`define BOUNDED_POSITIONAL_LIST_MACROS_SVH

// property that must hold on every edge out of reset
`define BPL_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define BPL_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPL_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/bpl_pkg.sv -----
// Shared types and codes for the bounded positional list.
// No dependencies; used by the store, the top level and the testbench.
package bpl_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int ACTION_W     = 4;
    localparam int POS_W        = 7;
    localparam int VALUE_W      = 32;
    localparam int STATUS_W     = 2;
    localparam int LEN_W        = 6;

    localparam logic [ACTION_W-1:0] ACT_INS_FRONT = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_INS_BACK  = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_INS_MID   = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_INS_POS   = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_DEL_FRONT = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_DEL_BACK  = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_DEL_MID   = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_DEL_POS   = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_LIST_FWD  = 4'd8;
    localparam logic [ACTION_W-1:0] ACT_LIST_BACK = 4'd9;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] element;
        logic [STATUS_W-1:0]       status;
        logic [LEN_W-1:0]          length;
        logic                      last_item;
    } rsp_t;

endpackage

// ----- hdl/bpl_stream_if.sv -----
// Valid/ready channel carrying one payload word per handshake.
// Payload type is set by the instantiating level (see bpl_pkg).
interface bpl_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/bpl_store.sv -----
// Element store: one write port, one read port with registered data.
// Depends on bpl_pkg for the element width.
module bpl_store #(
    parameter int DEPTH  = bpl_pkg::CAPACITY_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                               clk,
    input  logic                               wr_en,
    input  logic [ADDR_W-1:0]                  wr_addr,
    input  logic signed [bpl_pkg::VALUE_W-1:0] wr_data,
    input  logic                               rd_en,
    input  logic [ADDR_W-1:0]                  rd_addr,
    output logic signed [bpl_pkg::VALUE_W-1:0] rd_data
);

    logic signed [bpl_pkg::VALUE_W-1:0] mem [DEPTH];
    logic signed [bpl_pkg::VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/bounded_positional_list.sv -----
// Top level of the bounded positional list: request decode, shift sequencer,
// output register. Depends on bpl_pkg, bpl_stream_if, bpl_store and the macros header.
//
// Holds an ordered list of up to CAPACITY signed 32-bit values in a store with one
// write and one read port. Insert and delete move the elements behind the target one
// place at a time through one read/write pair and one shared +/-1 index adder.
// A listing gives one word per element, each by a store read, then an output
// load. Requests are taken one at a time: ready is high only while the
// sequencer is idle. Results leave through an output register, so a stalled
// consumer holds the sequencer but never loses a word.
`include "bounded_positional_list_macros.svh"

module bounded_positional_list #(
    parameter int CAPACITY = bpl_pkg::CAPACITY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    bpl_stream_if.sink          req,
    bpl_stream_if.source        rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = ((CNT_W > bpl_pkg::POS_W) ? CNT_W : bpl_pkg::POS_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_STEP,
        S_INS_MOVE,
        S_DEL_STEP,
        S_DEL_MOVE,
        S_LIST_RD,
        S_LIST_OUT,
        S_RESP
    } state_t;

    state_t                             state_reg, state_next;
    logic [CNT_W-1:0]                   count_reg, count_next;
    logic [CNT_W-1:0]                   ptr_reg, ptr_next;
    logic [CNT_W-1:0]                   tgt_reg, tgt_next;
    logic                               fwd_reg, fwd_next;
    logic signed [bpl_pkg::VALUE_W-1:0] value_reg, value_next;
    logic [bpl_pkg::STATUS_W-1:0]       status_reg, status_next;
    logic                               out_valid_reg, out_valid_next;
    bpl_pkg::rsp_t                      out_reg, out_next;

    logic                               wr_en;
    logic [IDX_W-1:0]                   wr_addr;
    logic signed [bpl_pkg::VALUE_W-1:0] wr_data;
    logic                               rd_en;
    logic [IDX_W-1:0]                   rd_addr;
    logic signed [bpl_pkg::VALUE_W-1:0] rd_data;

    // decode
    logic [CMP_W-1:0] n_ext, pos_ext, idx_ext;
    logic             is_ins, is_del, is_list, full, empty, bad_pos;
    // shared index unit
    logic [CNT_W-1:0] step_sum;
    logic             step_down;
    logic             out_free;
    logic [CNT_W-1:0] rev_idx;
    // check helpers
    logic             count_step_ok;
    logic             err_word;

    bpl_store #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;
    assign out_free    = !out_valid_reg || rsp.ready;

    assign step_down = (state_reg == S_INS_STEP) || (state_reg == S_INS_MOVE);
    assign step_sum  = ptr_reg + (step_down ? {CNT_W{1'b1}} : CNT_W'(1));
    assign rev_idx   = count_reg - CNT_W'(1) - ptr_reg;

    assign n_ext   = CMP_W'(count_reg);
    assign pos_ext = CMP_W'(req.payload.position);
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);

    always_comb
    begin
        is_ins  = 1'b0;
        is_del  = 1'b0;
        is_list = 1'b0;
        bad_pos = 1'b0;
        idx_ext = '0;
        case (req.payload.action)
            bpl_pkg::ACT_INS_FRONT:
            begin
                is_ins = 1'b1;
            end
            bpl_pkg::ACT_INS_BACK:
            begin
                is_ins  = 1'b1;
                idx_ext = n_ext;
            end
            bpl_pkg::ACT_INS_MID:
            begin
                is_ins  = 1'b1;
                idx_ext = (n_ext + CMP_W'(1)) >> 1;
            end
            bpl_pkg::ACT_INS_POS:
            begin
                is_ins  = 1'b1;
                idx_ext = pos_ext - CMP_W'(1);
                bad_pos = (pos_ext == '0) || (pos_ext > n_ext + CMP_W'(1));
            end
            bpl_pkg::ACT_DEL_FRONT:
            begin
                is_del = 1'b1;
            end
            bpl_pkg::ACT_DEL_BACK:
            begin
                is_del  = 1'b1;
                idx_ext = n_ext - CMP_W'(1);
            end
            bpl_pkg::ACT_DEL_MID:
            begin
                is_del  = 1'b1;
                idx_ext = n_ext >> 1;
            end
            bpl_pkg::ACT_DEL_POS:
            begin
                is_del  = 1'b1;
                idx_ext = pos_ext - CMP_W'(1);
                bad_pos = (pos_ext == '0) || (pos_ext > n_ext);
            end
            bpl_pkg::ACT_LIST_FWD,
            bpl_pkg::ACT_LIST_BACK:
            begin
                is_list = 1'b1;
            end
            default:
            begin
                is_ins = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        tgt_next       = tgt_reg;
        fwd_next       = fwd_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_next       = out_reg;
        wr_en          = 1'b0;
        wr_addr        = ptr_reg[IDX_W-1:0];
        wr_data        = rd_data;
        rd_en          = 1'b0;
        rd_addr        = step_sum[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    value_next  = req.payload.value;
                    fwd_next    = (req.payload.action == bpl_pkg::ACT_LIST_FWD);
                    status_next = bpl_pkg::ST_OK;
                    state_next  = S_RESP;
                    if (is_ins)
                    begin
                        if (full)
                        begin
                            status_next = bpl_pkg::ST_FULL;
                        end
                        else if (bad_pos)
                        begin
                            status_next = bpl_pkg::ST_RANGE;
                        end
                        else
                        begin
                            ptr_next   = count_reg;
                            tgt_next   = idx_ext[CNT_W-1:0];
                            state_next = S_INS_STEP;
                        end
                    end
                    else if (is_del || is_list)
                    begin
                        if (empty)
                        begin
                            status_next = bpl_pkg::ST_EMPTY;
                        end
                        else if (is_list)
                        begin
                            ptr_next   = '0;
                            state_next = S_LIST_RD;
                        end
                        else if (bad_pos)
                        begin
                            status_next = bpl_pkg::ST_RANGE;
                        end
                        else
                        begin
                            ptr_next   = idx_ext[CNT_W-1:0];
                            state_next = S_DEL_STEP;
                        end
                    end
                end
            end
            S_INS_STEP:
            begin
                if (ptr_reg == tgt_reg)
                begin
                    wr_en      = 1'b1;
                    wr_data    = value_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_RESP;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_INS_MOVE;
                end
            end
            S_INS_MOVE:
            begin
                wr_en      = 1'b1;
                ptr_next   = step_sum;
                state_next = S_INS_STEP;
            end
            S_DEL_STEP:
            begin
                if (step_sum >= count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_RESP;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_DEL_MOVE;
                end
            end
            S_DEL_MOVE:
            begin
                wr_en      = 1'b1;
                ptr_next   = step_sum;
                state_next = S_DEL_STEP;
            end
            S_LIST_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = fwd_reg ? ptr_reg[IDX_W-1:0] : rev_idx[IDX_W-1:0];
                state_next = S_LIST_OUT;
            end
            S_LIST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_next.element  = rd_data;
                    out_next.status   = bpl_pkg::ST_OK;
                    out_next.length   = bpl_pkg::LEN_W'(count_reg);
                    out_next.last_item = (step_sum == count_reg);
                    ptr_next          = step_sum;
                    state_next        = (step_sum == count_reg) ? S_IDLE : S_LIST_RD;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next.element   = '0;
                    out_next.status    = status_reg;
                    out_next.length    = bpl_pkg::LEN_W'(count_reg);
                    out_next.last_item = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            tgt_reg       <= '0;
            fwd_reg       <= 1'b0;
            status_reg    <= bpl_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            tgt_reg       <= tgt_next;
            fwd_reg       <= fwd_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload words, no reset
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        out_reg   <= out_next;
    end

    assign count_step_ok = (count_next == count_reg) ||
                           (count_next == count_reg + CNT_W'(1)) ||
                           (count_next + CNT_W'(1) == count_reg);
    assign err_word      = out_valid_reg && (out_reg.status != bpl_pkg::ST_OK);

    `BPL_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(CAPACITY), "count beyond capacity")
    `BPL_ASSERT(a_count_step, clk, rst_n, count_step_ok, "count moved by more than one")
    `BPL_ASSERT_IMPL(a_err_no_elem, clk, rst_n, err_word, out_reg.element == '0, "element on error")
    `BPL_ASSERT_IMPL(a_wr_busy, clk, rst_n, wr_en, !req.ready, "store written while idle")
    `BPL_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req.valid && req.ready, !req.ready, "double accept")

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for bounded_positional_list: directed corner cases, then random words.
// Depends on bpl_pkg and bpl_stream_if from the RTL; a scoreboard class predicts every result.

class list_scoreboard;
    localparam int CAP = bpl_pkg::CAPACITY_DEF;

    logic signed [bpl_pkg::VALUE_W-1:0] cells[$];
    bpl_pkg::rsp_t expected_q[$];
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;

    function int unsigned fill();
        return cells.size();
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    function void queue_result(logic signed [bpl_pkg::VALUE_W-1:0] elem,
                               logic [bpl_pkg::STATUS_W-1:0] st, logic last);
        bpl_pkg::rsp_t w;
        w.element   = elem;
        w.status    = st;
        w.length    = bpl_pkg::LEN_W'(cells.size());
        w.last_item = last;
        expected_q.push_back(w);
    endfunction

    function logic [bpl_pkg::STATUS_W-1:0] put_value(int unsigned idx,
                                                     logic signed [bpl_pkg::VALUE_W-1:0] v);
        if (cells.size() >= CAP)
            return bpl_pkg::ST_FULL;
        if (idx > cells.size())
            return bpl_pkg::ST_RANGE;
        cells.insert(idx, v);
        return bpl_pkg::ST_OK;
    endfunction

    function logic [bpl_pkg::STATUS_W-1:0] take_value(int unsigned idx);
        if (cells.size() == 0)
            return bpl_pkg::ST_EMPTY;
        if (idx >= cells.size())
            return bpl_pkg::ST_RANGE;
        cells.delete(idx);
        return bpl_pkg::ST_OK;
    endfunction

    // called for every accepted request word
    function void note_request(bpl_pkg::req_t r);
        int unsigned n;
        int unsigned k;
        logic [bpl_pkg::STATUS_W-1:0] st;
        n  = cells.size();
        st = bpl_pkg::ST_OK;
        case (r.action)
            bpl_pkg::ACT_INS_FRONT: st = put_value(0, r.value);
            bpl_pkg::ACT_INS_BACK:  st = put_value(n, r.value);
            bpl_pkg::ACT_INS_MID:   st = put_value((n + 1) / 2, r.value);
            bpl_pkg::ACT_INS_POS:
            begin
                // full takes priority over a bad position
                if (n >= CAP)
                    st = bpl_pkg::ST_FULL;
                else if (r.position == 0)
                    st = bpl_pkg::ST_RANGE;
                else
                    st = put_value(r.position - 1, r.value);
            end
            bpl_pkg::ACT_DEL_FRONT: st = take_value(0);
            bpl_pkg::ACT_DEL_BACK:  st = (n == 0) ? bpl_pkg::ST_EMPTY : take_value(n - 1);
            bpl_pkg::ACT_DEL_MID:   st = take_value(n / 2);
            bpl_pkg::ACT_DEL_POS:
            begin
                if (n == 0)
                    st = bpl_pkg::ST_EMPTY;
                else if (r.position == 0)
                    st = bpl_pkg::ST_RANGE;
                else
                    st = take_value(r.position - 1);
            end
            bpl_pkg::ACT_LIST_FWD, bpl_pkg::ACT_LIST_BACK:
            begin
                if (n == 0)
                    queue_result('0, bpl_pkg::ST_EMPTY, 1'b1);
                else
                begin
                    for (k = 0; k < n; k++)
                    begin
                        if (r.action == bpl_pkg::ACT_LIST_FWD)
                            queue_result(cells[k], bpl_pkg::ST_OK, k + 1 == n);
                        else
                            queue_result(cells[n - 1 - k], bpl_pkg::ST_OK, k + 1 == n);
                    end
                end
                return;
            end
            default: ; // spare codes: status only
        endcase
        queue_result('0, st, 1'b1);
    endfunction

    // called for every accepted result word
    function void check_result(bpl_pkg::rsp_t got);
        bpl_pkg::rsp_t want;
        results_seen++;
        if (expected_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected word: element %0d status %0d length %0d last %0d",
                         got.element, got.status, got.length, got.last_item);
            return;
        end
        want = expected_q.pop_front();
        if (got.element !== want.element || got.status !== want.status ||
            got.length !== want.length || got.last_item !== want.last_item)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("word %0d: exp %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                         results_seen, want.element, want.status, want.length,
                         want.last_item, got.element, got.status, got.length,
                         got.last_item);
        end
    endfunction

    function void finish_check();
        if (expected_q.size() != 0)
        begin
            if (mismatches < 10)
                $display("%0d expected words never arrived", expected_q.size());
            mismatches += expected_q.size();
        end
    endfunction
endclass

module testbench;
    localparam int CAP           = bpl_pkg::CAPACITY_DEF;
    localparam int RANDOM_ITEMS  = 155;
    localparam int IDLE_PCT      = 13;
    localparam int HOLD_CYCLES   = 250;
    localparam int WATCHDOG      = 2000;
    localparam int DRAIN_CYCLES  = 100;
    localparam logic [bpl_pkg::ACTION_W-1:0] ACT_SPARE_LO = 4'd10;
    localparam logic [bpl_pkg::ACTION_W-1:0] ACT_SPARE_HI = 4'd15;

    logic clk;
    logic rst_n;

    bpl_stream_if #(.payload_t(bpl_pkg::req_t)) req_if ();
    bpl_stream_if #(.payload_t(bpl_pkg::rsp_t)) rsp_if ();

    bounded_positional_list dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    list_scoreboard sb = new();

    int unsigned sent_count = 0;
    int unsigned stall_cycles = 0;
    int unsigned holds_done = 0;
    int unsigned full_hits = 0;
    int unsigned empty_hits = 0;
    bit growing = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function bit quiet_stretch();
        return sent_count >= 60 && sent_count < 110;
    endfunction

    // sample both channels at the rising edge; watchdog on cycles with no word moved
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_if.valid && req_if.ready)
            begin
                sb.note_request(req_if.payload);
                sent_count++;
            end
            if (rsp_if.valid && rsp_if.ready)
                sb.check_result(rsp_if.payload);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG)
            begin
                $display("watchdog: no traffic for %0d cycles", WATCHDOG);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // result side: random back-pressure plus two long hold-offs
    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if ((holds_done == 0 && sb.results_seen >= 40) ||
                (holds_done == 1 && sb.results_seen >= 220))
            begin
                holds_done++;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            rsp_if.ready <= quiet_stretch() || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // entered at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(bpl_pkg::req_t r);
        while (!quiet_stretch() && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        do
            @(posedge clk);
        while (!req_if.ready);
        @(negedge clk);
    endtask

    task automatic issue(logic [bpl_pkg::ACTION_W-1:0] act, int unsigned pos,
                         logic [bpl_pkg::VALUE_W-1:0] val);
        bpl_pkg::req_t r;
        r.action   = act;
        r.position = bpl_pkg::POS_W'(pos);
        r.value    = val;
        send_request(r);
    endtask

    // grow toward full, then shrink toward empty, with some noise mixed in
    task automatic make_random(output bpl_pkg::req_t r);
        int unsigned n;
        int unsigned pick;
        int unsigned kind;
        n = sb.fill();
        if (growing && n == CAP)
        begin
            full_hits++;
            if (full_hits >= 6)
            begin
                growing   = 1'b0;
                full_hits = 0;
            end
        end
        else if (!growing && n == 0)
        begin
            empty_hits++;
            if (empty_hits >= 4)
            begin
                growing    = 1'b1;
                empty_hits = 0;
            end
        end
        pick = $urandom_range(0, 99);
        if (pick < 75)
            kind = growing ? 0 : 1;
        else if (pick < 87)
            kind = growing ? 1 : 0;
        else if (pick < 95)
            kind = 2;
        else
            kind = 3;
        case (kind)
            0:
                case ($urandom_range(0, 3))
                    0: r.action = bpl_pkg::ACT_INS_FRONT;
                    1: r.action = bpl_pkg::ACT_INS_BACK;
                    2: r.action = bpl_pkg::ACT_INS_MID;
                    default: r.action = bpl_pkg::ACT_INS_POS;
                endcase
            1:
                case ($urandom_range(0, 3))
                    0: r.action = bpl_pkg::ACT_DEL_FRONT;
                    1: r.action = bpl_pkg::ACT_DEL_BACK;
                    2: r.action = bpl_pkg::ACT_DEL_MID;
                    default: r.action = bpl_pkg::ACT_DEL_POS;
                endcase
            2: r.action = $urandom_range(0, 1) ? bpl_pkg::ACT_LIST_FWD : bpl_pkg::ACT_LIST_BACK;
            default:
                r.action = bpl_pkg::ACTION_W'(ACT_SPARE_LO +
                                              $urandom_range(0, ACT_SPARE_HI - ACT_SPARE_LO));
        endcase
        if ($urandom_range(0, 3) == 0)
            r.position = bpl_pkg::POS_W'($urandom_range(0, 127));
        else
            r.position = bpl_pkg::POS_W'($urandom_range(0, n + 2));
        if ($urandom_range(0, 9) == 0)
            case ($urandom_range(0, 3))
                0: r.value = 32'h8000_0000;
                1: r.value = 32'h7fff_ffff;
                2: r.value = 32'h0000_0000;
                default: r.value = 32'hffff_ffff;
            endcase
        else
            r.value = $urandom;
    endtask

    initial
    begin
        bpl_pkg::req_t r;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rst_n          = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty list: listings and every delete
        issue(bpl_pkg::ACT_LIST_FWD, 1, 0);
        issue(bpl_pkg::ACT_LIST_BACK, 1, 0);
        issue(bpl_pkg::ACT_DEL_FRONT, 1, 0);
        issue(bpl_pkg::ACT_DEL_BACK, 1, 0);
        issue(bpl_pkg::ACT_DEL_MID, 1, 0);
        issue(bpl_pkg::ACT_DEL_POS, 1, 0);
        // insert position zero and one past the end
        issue(bpl_pkg::ACT_INS_POS, 0, 32'h1234_5678);
        issue(bpl_pkg::ACT_INS_POS, 2, 32'h1234_5678);
        issue(bpl_pkg::ACT_INS_POS, 1, 32'h8000_0000);
        issue(bpl_pkg::ACT_INS_FRONT, 1, 32'h7fff_ffff);
        issue(bpl_pkg::ACT_INS_BACK, 1, 32'h0000_0000);
        issue(bpl_pkg::ACT_INS_MID, 1, 32'hffff_ffff);
        issue(bpl_pkg::ACT_INS_POS, sb.fill() + 1, 32'h5a5a_a5a5);
        issue(bpl_pkg::ACT_INS_POS, 127, 32'h0f0f_0f0f);
        issue(bpl_pkg::ACT_LIST_FWD, 1, 0);
        issue(bpl_pkg::ACT_LIST_BACK, 1, 0);
        issue(bpl_pkg::ACT_DEL_POS, 0, 0);
        issue(bpl_pkg::ACT_DEL_POS, sb.fill() + 1, 0);
        issue(bpl_pkg::ACT_DEL_POS, 127, 0);
        issue(bpl_pkg::ACT_DEL_MID, 1, 0);
        issue(bpl_pkg::ACT_DEL_POS, sb.fill(), 0);
        issue(bpl_pkg::ACT_DEL_FRONT, 1, 0);
        issue(bpl_pkg::ACT_DEL_BACK, 1, 0);
        issue(ACT_SPARE_LO, 1, 32'hdead_beef);
        issue(ACT_SPARE_HI, 64, 32'hdead_beef);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            make_random(r);
            send_request(r);
        end
        req_if.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.finish_check();
        if (sb.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

// ----- bounded_positional_list.f -----
+incdir+hdl
hdl/bpl_pkg.sv
hdl/bpl_stream_if.sv
hdl/bpl_store.sv
hdl/bounded_positional_list.sv
dv/testbench.sv
